>>> sv/gamepad_switch_debouncer_macros.svh
// Assertion macros used by the debouncer merge stage.
`ifndef GAMEPAD_SWITCH_DEBOUNCER_MACROS_SVH
`define GAMEPAD_SWITCH_DEBOUNCER_MACROS_SVH

// Check a property on every rising edge of clk, quiet while rst_n is low.
`define GPSD_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define GPSD_NEVER(lbl, cond, msg) \
  `GPSD_CHECK(lbl, !(cond), msg)

`endif

>>> sv/gpsd_pkg.sv
// Shared constants and types for the gamepad switch debouncer.
package gpsd_pkg;

  localparam int PAD_W        = 4;
  localparam int BTN_W        = 18;
  localparam int TIME_W       = 32;
  localparam int DELAY_W      = 16;
  localparam int PAD_COUNT    = 4;
  localparam int BUTTON_COUNT = 18;

  // Lanes actually built: counts beyond the field width have no bit to filter.
  localparam int PAD_LANES = (PAD_COUNT < PAD_W) ? PAD_COUNT : PAD_W;
  localparam int BTN_LANES = (BUTTON_COUNT < BTN_W) ? BUTTON_COUNT : BTN_W;

  localparam int CLEAN_W = PAD_W + BTN_W;
  localparam int IN_W    = ((PAD_W + BTN_W + TIME_W + 7) / 8) * 8;
  localparam int OUT_W   = ((CLEAN_W + 7) / 8) * 8;

  localparam logic [DELAY_W-1:0] DELAY_RST = DELAY_W'(5);

  // Broadcast from the top level to every lane.
  typedef struct packed {
    logic               adv;
    logic [TIME_W-1:0]  now_ms;
    logic [DELAY_W-1:0] delay;
  } lane_ctl_t;

endpackage

>>> sv/gpsd_lane.sv
// One debounce lane: stable bit, last change time and the lockout compare.
module gpsd_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  gpsd_pkg::lane_ctl_t ctl,
  input  logic                strict_cmp,
  input  logic                raw_bit,
  output logic                clean_nxt
);
  import gpsd_pkg::*;

  logic              stable_r, stable_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] delay_ext;
  logic              ok;

  always_comb begin
    elapsed    = ctl.now_ms - time_r;
    delay_ext  = TIME_W'(ctl.delay);
    ok         = strict_cmp ? (elapsed > delay_ext) : (elapsed >= delay_ext);
    stable_nxt = stable_r;
    time_nxt   = time_r;
    // accept the change only once the lockout has run out
    if (ctl.adv && (raw_bit != stable_r) && ok) begin
      stable_nxt = raw_bit;
      time_nxt   = ctl.now_ms;
    end
    clean_nxt = stable_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= 1'b0;
      time_r   <= '0;
    end else begin
      stable_r <= stable_nxt;
      time_r   <= time_nxt;
    end
  end

endmodule

>>> sv/gpsd_merge.sv
// Merge of the lane results into one output item, with a skid stage.
`include "gamepad_switch_debouncer_macros.svh"

module gpsd_merge (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [gpsd_pkg::PAD_W-1:0]   pad_bits,
  input  logic [gpsd_pkg::BTN_W-1:0]   btn_bits,
  output logic                         room,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [gpsd_pkg::OUT_W-1:0]   out_tdata
);
  import gpsd_pkg::*;

  logic [CLEAN_W-1:0] word;
  logic [CLEAN_W-1:0] main_data_r, main_data_nxt;
  logic [CLEAN_W-1:0] skid_data_r, skid_data_nxt;
  logic               main_vld_r, main_vld_nxt;
  logic               skid_vld_r, skid_vld_nxt;
  logic               pop;

  assign word       = {btn_bits, pad_bits};
  assign room       = !skid_vld_r;
  assign out_tvalid = main_vld_r;
  assign out_tdata  = OUT_W'(main_data_r);
  assign pop        = main_vld_r && out_tready;

  always_comb begin
    main_data_nxt = main_data_r;
    skid_data_nxt = skid_data_r;
    main_vld_nxt  = main_vld_r;
    skid_vld_nxt  = skid_vld_r;
    if (skid_vld_r) begin
      // drain the skid entry first; no push can arrive meanwhile
      if (pop) begin
        main_data_nxt = skid_data_r;
        skid_vld_nxt  = 1'b0;
      end
    end else if (push) begin
      if (!main_vld_r || pop) begin
        main_data_nxt = word;
        main_vld_nxt  = 1'b1;
      end else begin
        skid_data_nxt = word;
        skid_vld_nxt  = 1'b1;
      end
    end else if (pop) begin
      main_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_data_r <= main_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  `GPSD_NEVER(a_skid_without_main, skid_vld_r && !main_vld_r,
              "skid holds an item but output is empty")
  `GPSD_CHECK(a_stall_fills_skid, push && main_vld_r && !out_tready |=> skid_vld_r,
              "stalled item not held in skid")
  `GPSD_CHECK(a_skid_moves_up,
              skid_vld_r && pop |=> main_vld_r && (main_data_r == $past(skid_data_r)),
              "skid item lost on drain")
  `GPSD_CHECK(a_empty_load,
              push && !main_vld_r |=> main_vld_r && (main_data_r == $past(word)),
              "item not loaded into empty output")

endmodule

>>> sv/gamepad_switch_debouncer.sv
// Top level of the gamepad switch debouncer: field unpacking, lanes and merge.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+---------------------------------------
//  in_     | input     | in_tvalid/tready  | raw_pad, raw_buttons, now_ms (56 bits)
//  out_    | output    | out_tvalid/tready | clean_pad, clean_buttons (24 bits)
//  cfg_    | input     | cfg_we            | debounce_delay_ms (16 bits)
//
// One item per cycle while in_tready is high: every bit has its own lane, so the only
// path between registers is one 32-bit subtract and compare per lane.
// An accepted item's result is registered into the output register, or into the skid stage while the output is held.
// The output register plus a one-item skid stage keep in_tready registered;
// in_tready drops only while both hold an item the output side has not taken.
// Synchronous reset clears the debounced bits, the change times and the
// output stage, and sets the delay to 5 ms.
module gamepad_switch_debouncer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // raw_pad [3:0], raw_buttons [21:4], now_ms [53:22], zero [55:54]
  input  logic [gpsd_pkg::IN_W-1:0]         in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // clean_pad [3:0], clean_buttons [21:4], zero [23:22]
  output logic [gpsd_pkg::OUT_W-1:0]        out_tdata,
  input  logic                              cfg_we,
  input  logic [gpsd_pkg::DELAY_W-1:0]      cfg_wdata
);
  import gpsd_pkg::*;

  logic [DELAY_W-1:0] delay_r, delay_nxt;
  logic [PAD_W-1:0]   raw_pad;
  logic [BTN_W-1:0]   raw_buttons;
  logic [TIME_W-1:0]  now_ms;
  logic [PAD_W-1:0]   clean_pad;
  logic [BTN_W-1:0]   clean_buttons;
  logic               push;
  lane_ctl_t          ctl;

  // Unpack the item: fields sit from bit 0 upward, no gaps.
  assign raw_pad     = in_tdata[PAD_W-1:0];
  assign raw_buttons = in_tdata[PAD_W +: BTN_W];
  assign now_ms      = in_tdata[PAD_W+BTN_W +: TIME_W];

  assign push = in_tvalid && in_tready;

  // Hold the delay until the next write.
  assign delay_nxt = cfg_we ? cfg_wdata : delay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RST;
    end else begin
      delay_r <= delay_nxt;
    end
  end

  assign ctl.adv    = push;
  assign ctl.now_ms = now_ms;
  assign ctl.delay  = delay_r;

  // Pad lanes use a strict compare, button lanes an inclusive one.
  // Bits above the lane counts are never debounced and read as zero.
  genvar gi;
  generate
    for (gi = 0; gi < PAD_W; gi++) begin : g_pad
      if (gi < PAD_LANES) begin : g_lane
        gpsd_lane u_lane (
          .clk        (clk),
          .rst_n      (rst_n),
          .ctl        (ctl),
          .strict_cmp (1'b1),
          .raw_bit    (raw_pad[gi]),
          .clean_nxt  (clean_pad[gi])
        );
      end else begin : g_zero
        assign clean_pad[gi] = 1'b0;
      end
    end
    for (gi = 0; gi < BTN_W; gi++) begin : g_btn
      if (gi < BTN_LANES) begin : g_lane
        gpsd_lane u_lane (
          .clk        (clk),
          .rst_n      (rst_n),
          .ctl        (ctl),
          .strict_cmp (1'b0),
          .raw_bit    (raw_buttons[gi]),
          .clean_nxt  (clean_buttons[gi])
        );
      end else begin : g_zero
        assign clean_buttons[gi] = 1'b0;
      end
    end
  endgenerate

  // Gather the lane bits into one item and hand it on through the skid stage.
  gpsd_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pad_bits   (clean_pad),
    .btn_bits   (clean_buttons),
    .room       (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
